### design/min_palindrome_partition_defines.svh
// Assertion macros used by the top-level design file.
`ifndef MIN_PALINDROME_PARTITION_DEFINES_SVH
`define MIN_PALINDROME_PARTITION_DEFINES_SVH

// Checked on aclk, off while aresetn is low.
`define MPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Signal carries no X or Z once out of reset.
`define MPP_ASSERT_KNOWN(label, sig, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !$isunknown(sig)) else $error(msg);

`endif

### design/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Sizes and shared types for the minimum palindrome partition block.
// ----------------------------------------------------------------------------
package mpp_pkg;

    localparam int MAX_LEN   = 64;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int SYM_W     = 8;
    localparam int BEST_W    = 7;
    localparam int MIR_DEPTH = MAX_LEN * MAX_LEN;
    localparam int MIR_AW    = $clog2(MIR_DEPTH);

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
    } solve_req_t;

    typedef struct packed {
        logic              done;
        logic [BEST_W-1:0] pieces;
    } solve_rsp_t;

endpackage

### design/mpp_ram.sv
// ----------------------------------------------------------------------------
// mpp_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/mpp_solver.sv
// ----------------------------------------------------------------------------
// mpp_solver
// Row sweep, bottom row first: each step builds one mirror flag and folds
// one piece candidate into the row's best count.
// ----------------------------------------------------------------------------
module mpp_solver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mpp_pkg::solve_req_t           req,
    output mpp_pkg::solve_rsp_t           rsp,
    output logic [mpp_pkg::IDX_W-1:0]     sym_rd_addr,
    input  logic [mpp_pkg::SYM_W-1:0]     sym_rd_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_SWEEP = 5'b00100,
        S_DRAIN = 5'b01000,
        S_WRITE = 5'b10000
    } sol_state_t;

    sol_state_t state_reg, state_next;

    logic [mpp_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [mpp_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [mpp_pkg::IDX_W-1:0]  j_reg, j_next;
    logic [mpp_pkg::IDX_W-1:0]  p_j_reg;
    logic                       p_valid_reg, p_last_reg;
    logic [mpp_pkg::SYM_W-1:0]  si_reg;
    logic [mpp_pkg::BEST_W-1:0] best_reg, best_next;

    logic [mpp_pkg::IDX_W-1:0]  last_col;
    logic [mpp_pkg::CNT_W-1:0]  n_m1;
    logic                       mir_rd_data, flag;
    logic [mpp_pkg::MIR_AW-1:0] mir_rd_addr, mir_wr_addr;
    logic [mpp_pkg::BEST_W-1:0] best_rd_data, cand;
    logic [mpp_pkg::IDX_W-1:0]  span;

    assign n_m1     = n_reg - mpp_pkg::CNT_W'(1);
    assign last_col = n_m1[mpp_pkg::IDX_W-1:0];

    // Flag of (i+1, j-1); only used where j-i >= 2, so wrap at the edges is harmless.
    assign mir_rd_addr = mpp_pkg::MIR_AW'(
        (mpp_pkg::MIR_AW'(i_reg) + mpp_pkg::MIR_AW'(1)) * mpp_pkg::MIR_AW'(mpp_pkg::MAX_LEN)
        + mpp_pkg::MIR_AW'(j_reg) - mpp_pkg::MIR_AW'(1));
    assign mir_wr_addr = mpp_pkg::MIR_AW'(
        mpp_pkg::MIR_AW'(i_reg) * mpp_pkg::MIR_AW'(mpp_pkg::MAX_LEN)
        + mpp_pkg::MIR_AW'(p_j_reg));

    assign sym_rd_addr = (state_reg == S_START) ? i_reg : j_reg;

    mpp_ram #(.WIDTH(1), .DEPTH(mpp_pkg::MIR_DEPTH)) u_mirror (
        .aclk    (aclk),
        .wr_en   (p_valid_reg),
        .wr_addr (mir_wr_addr),
        .wr_data (flag),
        .rd_addr (mir_rd_addr),
        .rd_data (mir_rd_data)
    );

    mpp_ram #(.WIDTH(mpp_pkg::BEST_W), .DEPTH(mpp_pkg::MAX_LEN)) u_best (
        .aclk    (aclk),
        .wr_en   (state_reg == S_WRITE),
        .wr_addr (i_reg),
        .wr_data (best_reg),
        .rd_addr (j_reg + mpp_pkg::IDX_W'(1)),
        .rd_data (best_rd_data)
    );

    assign span = p_j_reg - i_reg;
    assign flag = (si_reg == sym_rd_data) && ((span < mpp_pkg::IDX_W'(2)) || mir_rd_data);
    assign cand = p_last_reg ? mpp_pkg::BEST_W'(1) : best_rd_data + mpp_pkg::BEST_W'(1);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        best_next  = best_reg;
        if (p_valid_reg && flag && (cand < best_reg)) begin
            best_next = cand;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    n_next     = req.n;
                    i_next     = mpp_pkg::IDX_W'(req.n - mpp_pkg::CNT_W'(1));
                    state_next = S_START;
                end
            end
            S_START: begin
                j_next     = i_reg;
                best_next  = '1;
                state_next = S_SWEEP;
            end
            S_SWEEP: begin
                if (j_reg == last_col) begin
                    state_next = S_DRAIN;
                end else begin
                    j_next = j_reg + mpp_pkg::IDX_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (i_reg == '0) begin
                    state_next = S_IDLE;
                end else begin
                    i_next     = i_reg - mpp_pkg::IDX_W'(1);
                    state_next = S_START;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            p_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == S_SWEEP);
        end
        n_reg      <= n_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        best_reg   <= best_next;
        p_j_reg    <= j_reg;
        p_last_reg <= (j_reg == last_col);
        // symbol i arrives in the first sweep cycle
        if (state_reg == S_SWEEP && j_reg == i_reg) begin
            si_reg <= sym_rd_data;
        end
    end

    assign rsp.done   = (state_reg == S_WRITE) && (i_reg == '0);
    assign rsp.pieces = best_reg;

endmodule

### design/min_palindrome_partition.sv
// ----------------------------------------------------------------------------
// min_palindrome_partition
// Loads a string, then finds the fewest palindromic pieces that cover it.
// ----------------------------------------------------------------------------
//  channel | ports                                | moves
//  s_      | s_valid s_ready s_symbol s_last_symbol | one symbol per item
//  m_      | m_valid m_ready m_piece_count m_too_long | one result per string
//
// Symbols load at one per cycle while s_ready is high. After the last symbol,
// the row sweep runs over the mirror-flag RAM, reading and writing it at each
// step, then the result is handed to the output register.
// Too-long strings skip the sweep. s_ready is low during the sweep and while
// a new result waits on a full output register. No clearing pass after reset.
module min_palindrome_partition (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mpp_pkg::SYM_W-1:0]     s_symbol,
    input  logic                          s_last_symbol,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mpp_pkg::BEST_W-1:0]    m_piece_count,
    output logic                          m_too_long
);

`include "min_palindrome_partition_defines.svh"

    typedef enum logic [2:0] {
        T_LOAD   = 3'b001,
        T_SOLVE  = 3'b010,
        T_FINISH = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [mpp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [mpp_pkg::BEST_W-1:0] res_count_reg, res_count_next;
    logic                       res_long_reg, res_long_next;
    logic                       m_valid_reg, m_valid_next;
    logic [mpp_pkg::BEST_W-1:0] m_count_reg, m_count_next;
    logic                       m_long_reg, m_long_next;

    mpp_pkg::solve_req_t        req;
    mpp_pkg::solve_rsp_t        rsp;
    logic [mpp_pkg::IDX_W-1:0]  sym_rd_addr;
    logic [mpp_pkg::SYM_W-1:0]  sym_rd_data;
    logic                       accept, full, sym_we;

    assign s_ready = (state_reg == T_LOAD);
    assign accept  = s_valid && s_ready;
    assign full    = (cnt_reg == mpp_pkg::CNT_W'(mpp_pkg::MAX_LEN));
    assign sym_we  = accept && !full;

    mpp_ram #(.WIDTH(mpp_pkg::SYM_W), .DEPTH(mpp_pkg::MAX_LEN)) u_symbols (
        .aclk    (aclk),
        .wr_en   (sym_we),
        .wr_addr (cnt_reg[mpp_pkg::IDX_W-1:0]),
        .wr_data (s_symbol),
        .rd_addr (sym_rd_addr),
        .rd_data (sym_rd_data)
    );

    assign req.start = accept && s_last_symbol && !ovf_reg && !full;
    assign req.n     = cnt_reg + mpp_pkg::CNT_W'(1);

    mpp_solver u_solver (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .rsp         (rsp),
        .sym_rd_addr (sym_rd_addr),
        .sym_rd_data (sym_rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        res_count_next = res_count_reg;
        res_long_next  = res_long_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_count_next   = m_count_reg;
        m_long_next    = m_long_reg;
        unique case (state_reg)
            T_LOAD: begin
                if (accept) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        cnt_next = cnt_reg + mpp_pkg::CNT_W'(1);
                    end
                    if (s_last_symbol) begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                        if (ovf_reg || full) begin
                            res_count_next = '0;
                            res_long_next  = 1'b1;
                            state_next     = T_FINISH;
                        end else begin
                            state_next = T_SOLVE;
                        end
                    end
                end
            end
            T_SOLVE: begin
                if (rsp.done) begin
                    res_count_next = rsp.pieces;
                    res_long_next  = 1'b0;
                    state_next     = T_FINISH;
                end
            end
            T_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = res_count_reg;
                    m_long_next  = res_long_reg;
                    state_next   = T_LOAD;
                end
            end
            default: state_next = T_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        res_count_reg <= res_count_next;
        res_long_reg  <= res_long_next;
        m_count_reg   <= m_count_next;
        m_long_reg    <= m_long_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_piece_count = m_count_reg;
    assign m_too_long    = m_long_reg;

    `MPP_ASSERT(a_done_in_solve, rsp.done |-> (state_reg == T_SOLVE), "solver done outside solve")
    `MPP_ASSERT(a_result_from_finish, $rose(m_valid) |-> $past(state_reg == T_FINISH), "stray result")
    `MPP_ASSERT(a_long_zero, (m_valid && m_too_long) |-> (m_piece_count == '0), "too long with count")
    `MPP_ASSERT_KNOWN(a_valid_known, m_valid, "m_valid unknown")

endmodule

### tb/min_palindrome_partition_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_palindrome_partition_tb
// Feeds strings one symbol per item. Each piece count is checked against a
// table value or a local minimum-partition solver. The run covers short, full
// and overflowing strings, random idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
module min_palindrome_partition_tb;

    typedef struct {
        logic [mpp_pkg::BEST_W-1:0] pieces;
        logic                       too_long;
    } count_t;

    typedef struct {
        logic [mpp_pkg::SYM_W-1:0] sym;
        logic                      last;
        bit                        typed;
        int                        pieces;
        bit                        too_long;
    } stim_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [mpp_pkg::SYM_W-1:0]    s_symbol;
    logic                         s_last_symbol;
    logic                         m_valid;
    logic                         m_ready;
    logic [mpp_pkg::BEST_W-1:0]   m_piece_count;
    logic                         m_too_long;

    count_t                    count_q[$];
    logic [mpp_pkg::SYM_W-1:0] string_q[$];
    int               mismatches = 0;
    int               items_sent = 0;
    int               results_seen = 0;
    int               overflow_strings = 0;
    bit               first_item = 1;
    bit               quiet = 0;
    bit               hold_req = 0;

    min_palindrome_partition uut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Fewest palindromic pieces over the whole string.
    function automatic int min_pieces(logic [mpp_pkg::SYM_W-1:0] str[$]);
        int n;
        int best[mpp_pkg::MAX_LEN+1];
        bit mirror[mpp_pkg::MAX_LEN][mpp_pkg::MAX_LEN];
        n = str.size();
        for (int i = n - 1; i >= 0; i--)
            for (int j = i; j < n; j++)
                mirror[i][j] = (str[i] == str[j]) && (j - i < 2 || mirror[i+1][j-1]);
        best[n] = 0;
        for (int i = n - 1; i >= 0; i--) begin
            best[i] = mpp_pkg::MAX_LEN + 1;
            for (int k = i; k < n; k++)
                if (mirror[i][k] && best[k+1] + 1 < best[i])
                    best[i] = best[k+1] + 1;
        end
        return best[0];
    endfunction

    // Drives one item, waits for acceptance, then updates the expected counts.
    task automatic send_symbol(logic [mpp_pkg::SYM_W-1:0] sym, logic last, bit typed = 0,
                               int t_pieces = 0, bit t_long = 0);
        int gap;
        count_t c;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (!first_item && gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        first_item = 0;
        s_valid       <= 1'b1;
        s_symbol      <= sym;
        s_last_symbol <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        string_q.push_back(sym);
        if (last) begin
            if (typed) begin
                c.pieces   = mpp_pkg::BEST_W'(t_pieces);
                c.too_long = t_long;
            end else if (string_q.size() > mpp_pkg::MAX_LEN) begin
                c.pieces   = '0;
                c.too_long = 1'b1;
            end else begin
                c.pieces   = mpp_pkg::BEST_W'(min_pieces(string_q));
                c.too_long = 1'b0;
            end
            if (c.too_long) overflow_strings++;
            count_q.push_back(c);
            string_q.delete();
        end
    endtask

    task automatic send_string(int len, int alphabet);
        logic [mpp_pkg::SYM_W-1:0] letters[4];
        foreach (letters[i]) letters[i] = mpp_pkg::SYM_W'($urandom);
        for (int i = 0; i < len; i++)
            send_symbol(alphabet == 0 ? mpp_pkg::SYM_W'($urandom) :
                        letters[2'($urandom_range(0, alphabet - 1))], i == len - 1);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        int hold;
        count_t e;
        stall = 0;
        hold  = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (count_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pieces=%0d too_long=%0b",
                                 m_piece_count, m_too_long);
                end else begin
                    e = count_q.pop_front();
                    if (e.pieces !== m_piece_count || e.too_long !== m_too_long) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pieces exp %0d got %0d, too_long exp %0b got %0b",
                                     e.pieces, m_piece_count, e.too_long, m_too_long);
                    end
                end
                stall = quiet ? 0 : $urandom_range(0, 10);
            end
            if (hold_req) begin
                hold_req = 0;
                hold = 3000;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    stim_row_t table_rows[] = '{
        '{8'h61, 1'b1, 1, 1, 0},
        '{8'h00, 1'b0, 0, 0, 0}, '{8'hFF, 1'b1, 1, 2, 0},
        '{8'hFF, 1'b0, 0, 0, 0}, '{8'h00, 1'b0, 0, 0, 0}, '{8'hFF, 1'b1, 1, 1, 0},
        '{8'h61, 1'b0, 0, 0, 0}, '{8'h62, 1'b0, 0, 0, 0}, '{8'h63, 1'b1, 1, 3, 0},
        '{8'h80, 1'b0, 0, 0, 0}, '{8'h7F, 1'b1, 1, 2, 0},
        '{8'h61, 1'b0, 0, 0, 0}, '{8'h61, 1'b0, 0, 0, 0}, '{8'h62, 1'b0, 0, 0, 0},
        '{8'h61, 1'b0, 0, 0, 0}, '{8'h62, 1'b1, 0, 0, 0},
        '{8'h55, 1'b0, 0, 0, 0}, '{8'hAA, 1'b0, 0, 0, 0}, '{8'h55, 1'b0, 0, 0, 0},
        '{8'h55, 1'b1, 0, 0, 0}
    };

    initial begin
        int len;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_symbol      = '0;
        s_last_symbol = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[r])
            send_symbol(table_rows[r].sym, table_rows[r].last, table_rows[r].typed,
                        table_rows[r].pieces, table_rows[r].too_long);
        // full store of one symbol, then one symbol past the store
        for (int i = 0; i < mpp_pkg::MAX_LEN; i++)
            send_symbol(8'h5A, i == mpp_pkg::MAX_LEN - 1, 1, 1, 0);
        for (int i = 0; i <= mpp_pkg::MAX_LEN; i++)
            send_symbol(8'hA5, i == mpp_pkg::MAX_LEN, 1, 0, 1);
        send_string(mpp_pkg::MAX_LEN, 2);

        // receiver holds off while several strings queue up behind it
        hold_req = 1;
        for (int s = 0; s < 6; s++) send_string($urandom_range(1, 6), 2);
        // sender waits for every result before going on
        s_valid <= 1'b0;
        first_item = 1;
        wait (count_q.size() == 0);
        @(posedge aclk);

        while (items_sent < 600) begin
            quiet = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(mpp_pkg::MAX_LEN - 4, mpp_pkg::MAX_LEN + 6);
                1, 2:    len = $urandom_range(1, 12);
                default: len = $urandom_range(1, 12);
            endcase
            send_string(len, (len > 20 || $urandom_range(0, 4) == 0) ? 0 :
                             $urandom_range(1, 3));
        end
        quiet = 0;
        s_valid <= 1'b0;

        wait (count_q.size() == 0);
        repeat (3000) @(posedge aclk);
        $display("Sent %0d symbols; checked %0d piece counts, %0d of them overflowed.",
                 items_sent, results_seen, overflow_strings);
        if (mismatches == 0 && count_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/mpp_pkg.sv
design/mpp_ram.sv
design/mpp_solver.sv
design/min_palindrome_partition.sv
tb/min_palindrome_partition_tb.sv
